// ----- design/quadratic_root_solver_core_defines.svh -----
// Assertion macros for the quadratic root solver.
// Each macro asserts one concurrent property on clk, disabled during rst.
`ifndef QUADRATIC_ROOT_SOLVER_CORE_DEFINES_SVH
`define QUADRATIC_ROOT_SOLVER_CORE_DEFINES_SVH

// Same-cycle implication.
`define QRS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define QRS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- design/qrs_pkg.sv -----
// ----------------------------------------------------------------------------
// qrs_pkg
// Widths, kind codes, sideband types and helpers for the quadratic root solver.
// ----------------------------------------------------------------------------
package qrs_pkg;

  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 16;

  // Magnitudes and products.
  localparam int MAG_W  = WORD_BITS;
  localparam int PROD_W = 2 * WORD_BITS;
  // |b*b - 4ac| fits in 2*WORD+1 bits.
  localparam int DISC_W = 2 * WORD_BITS + 1;
  // Radicand is disc << 2*FRAC, padded to an even width.
  localparam int RAD_RAW = DISC_W + 2 * FRAC_BITS;
  localparam int RAD_W   = RAD_RAW + (RAD_RAW % 2);
  localparam int ROOT_W  = RAD_W / 2;
  localparam int SREM_W  = ROOT_W + 2;
  // Divider: divisor is 2|a|.
  localparam int DEN_W  = WORD_BITS + 1;
  localparam int MNUM_W = WORD_BITS + FRAC_BITS;
  localparam int DVD_W  = (ROOT_W > MNUM_W) ? ROOT_W : MNUM_W;
  localparam int DREM_W = DEN_W;
  // Signed width for m +/- n.
  localparam int SUM_W  = DVD_W + 3;

  localparam logic [1:0] KIND_COMPLEX  = 2'd0;
  localparam logic [1:0] KIND_REPEATED = 2'd1;
  localparam logic [1:0] KIND_DISTINCT = 2'd2;
  localparam logic [1:0] KIND_A_ZERO   = 2'd3;

  typedef struct packed {
    logic a_zero;
    logic dneg;
    logic dzero;
    logic m_neg;
    logic n_neg;
  } flags_t;

  typedef struct packed {
    flags_t             flags;
    logic [DEN_W-1:0]   den;
    logic [DVD_W-1:0]   mnum;
  } sqrt_side_t;

  function automatic logic [WORD_BITS-1:0] sat_word(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] lo;
    hi = SUM_W'((64'sd1 <<< (WORD_BITS - 1)) - 64'sd1);
    lo = -hi - SUM_W'(1);
    if (v > hi) begin
      return hi[WORD_BITS-1:0];
    end else if (v < lo) begin
      return lo[WORD_BITS-1:0];
    end
    return v[WORD_BITS-1:0];
  endfunction

endpackage

// ----- design/qrs_sqrt.sv -----
// ----------------------------------------------------------------------------
// qrs_sqrt
// Pipelined integer square root, one root bit per stage, sideband carried along.
// ----------------------------------------------------------------------------
module qrs_sqrt import qrs_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [RAD_W-1:0]  radicand,
  input  sqrt_side_t        in_side,
  output logic              out_valid,
  output logic [ROOT_W-1:0] root,
  output sqrt_side_t        out_side
);

  logic              vld  [0:ROOT_W];
  logic [RAD_W-1:0]  x    [0:ROOT_W];
  logic [SREM_W-1:0] rem  [0:ROOT_W];
  logic [ROOT_W-1:0] rt   [0:ROOT_W];
  sqrt_side_t        side [0:ROOT_W];

  assign vld[0]  = in_valid;
  assign x[0]    = radicand;
  assign rem[0]  = '0;
  assign rt[0]   = '0;
  assign side[0] = in_side;

  for (genvar g = 0; g < ROOT_W; g++) begin : g_stage
    logic [SREM_W+1:0] t;
    logic [SREM_W+1:0] trial;
    logic [SREM_W+1:0] diff;
    logic              ge;

    always_comb begin
      t     = {rem[g], x[g][RAD_W-1 -: 2]};
      trial = {(SREM_W + 2 - ROOT_W - 2)'(0), rt[g], 2'b01};
      ge    = (t >= trial);
      diff  = t - trial;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[g+1] <= 1'b0;
      end else begin
        vld[g+1] <= vld[g];
      end
      x[g+1]    <= {x[g][RAD_W-3:0], 2'b00};
      rem[g+1]  <= ge ? diff[SREM_W-1:0] : t[SREM_W-1:0];
      rt[g+1]   <= {rt[g][ROOT_W-2:0], ge};
      side[g+1] <= side[g];
    end
  end

  assign out_valid = vld[ROOT_W];
  assign root      = rt[ROOT_W];
  assign out_side  = side[ROOT_W];

endmodule

// ----- design/qrs_div.sv -----
// ----------------------------------------------------------------------------
// qrs_div
// Two-lane pipelined restoring divider sharing one divisor, one bit per stage.
// ----------------------------------------------------------------------------
module qrs_div import qrs_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic [DVD_W-1:0] dvd_m,
  input  logic [DVD_W-1:0] dvd_n,
  input  logic [DEN_W-1:0] den,
  input  flags_t           in_flags,
  output logic             out_valid,
  output logic [DVD_W-1:0] quo_m,
  output logic [DVD_W-1:0] quo_n,
  output flags_t           out_flags
);

  logic              vld   [0:DVD_W];
  logic [DVD_W-1:0]  qm    [0:DVD_W];
  logic [DVD_W-1:0]  qn    [0:DVD_W];
  logic [DREM_W-1:0] rm    [0:DVD_W];
  logic [DREM_W-1:0] rn    [0:DVD_W];
  logic [DEN_W-1:0]  dd    [0:DVD_W];
  flags_t            flg   [0:DVD_W];

  assign vld[0] = in_valid;
  assign qm[0]  = dvd_m;
  assign qn[0]  = dvd_n;
  assign rm[0]  = '0;
  assign rn[0]  = '0;
  assign dd[0]  = den;
  assign flg[0] = in_flags;

  for (genvar g = 0; g < DVD_W; g++) begin : g_stage
    logic [DREM_W:0] tm;
    logic [DREM_W:0] tn;
    logic [DREM_W:0] dm;
    logic [DREM_W:0] dn;
    logic            gm;
    logic            gn;

    always_comb begin
      tm = {rm[g], qm[g][DVD_W-1]};
      tn = {rn[g], qn[g][DVD_W-1]};
      gm = (tm >= {1'b0, dd[g]});
      gn = (tn >= {1'b0, dd[g]});
      dm = tm - {1'b0, dd[g]};
      dn = tn - {1'b0, dd[g]};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[g+1] <= 1'b0;
      end else begin
        vld[g+1] <= vld[g];
      end
      rm[g+1]  <= gm ? dm[DREM_W-1:0] : tm[DREM_W-1:0];
      rn[g+1]  <= gn ? dn[DREM_W-1:0] : tn[DREM_W-1:0];
      qm[g+1]  <= {qm[g][DVD_W-2:0], gm};
      qn[g+1]  <= {qn[g][DVD_W-2:0], gn};
      dd[g+1]  <= dd[g];
      flg[g+1] <= flg[g];
    end
  end

  assign out_valid = vld[DVD_W];
  assign quo_m     = qm[DVD_W];
  assign quo_n     = qn[DVD_W];
  assign out_flags = flg[DVD_W];

endmodule

// ----- design/quadratic_root_solver_core.sv -----
// ----------------------------------------------------------------------------
// quadratic_root_solver_core
// Roots of a*x^2 + b*x + c in signed Q16.16, fully pipelined.
// ----------------------------------------------------------------------------
// Usage:
//   Drive coef_a, coef_b, coef_c and raise start; a beat is taken at every
//   rising edge with start high and busy low. busy is always low: the
//   pipeline takes one beat per cycle with no gaps.
//   Each result beat shows on root_kind, first_value, second_value for one
//   cycle with done high, in the order in which the beats were taken.
//   Latency is set by the square root (one root bit per stage, 49 stages)
//   followed by the divider (one quotient bit per stage, 49 stages), plus
//   input, multiply, discriminant and output registers.
//   Throughput: one beat per cycle, back to back.
//   Reset (rst, synchronous) clears all valid bits; beats in flight are
//   dropped. The receiver cannot stall; results are never held.
//   root_kind: complex pair, repeated root, distinct roots, or a is zero
//   (then both values are 0). Values saturate to the 32-bit range.
// ----------------------------------------------------------------------------
`include "quadratic_root_solver_core_defines.svh"

module quadratic_root_solver_core import qrs_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  logic signed [31:0]     coef_a,
  input  logic signed [31:0]     coef_b,
  input  logic signed [31:0]     coef_c,
  output logic                   done,
  output logic [1:0]             root_kind,
  output logic signed [31:0]     first_value,
  output logic signed [31:0]     second_value
);

  // Never stalls.
  assign busy = 1'b0;

  // Stage 1: input capture.
  logic                        v1;
  logic signed [WORD_BITS-1:0] a1, b1, c1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= start && !busy;
    end
    a1 <= coef_a;
    b1 <= coef_b;
    c1 <= coef_c;
  end

  // Magnitudes; -2^31 maps to 2^31 as an unsigned pattern.
  logic [MAG_W-1:0] ma1, mb1, mc1;
  assign ma1 = a1[WORD_BITS-1] ? MAG_W'(-a1) : MAG_W'(a1);
  assign mb1 = b1[WORD_BITS-1] ? MAG_W'(-b1) : MAG_W'(b1);
  assign mc1 = c1[WORD_BITS-1] ? MAG_W'(-c1) : MAG_W'(c1);

  // Stage 2: products b*b and |a||c|.
  logic              v2;
  logic [PROD_W-1:0] bb2, ac2;
  logic [MAG_W-1:0]  ma2, mb2;
  logic              a_neg2, c_neg2, c_zero2, a_zero2, b_neg2, b_zero2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    bb2     <= mb1 * mb1;
    ac2     <= ma1 * mc1;
    ma2     <= ma1;
    mb2     <= mb1;
    a_neg2  <= a1[WORD_BITS-1];
    c_neg2  <= c1[WORD_BITS-1];
    c_zero2 <= (c1 == '0);
    a_zero2 <= (a1 == '0);
    b_neg2  <= b1[WORD_BITS-1];
    b_zero2 <= (b1 == '0);
  end

  // Stage 3: discriminant magnitude and sign.
  logic [DISC_W:0] bsq, fac, dsum, dbf, dfb, dsel;
  logic            dneg_c;

  always_comb begin
    bsq  = (DISC_W + 1)'(bb2);
    fac  = {ac2, 2'b00};
    dsum = bsq + fac;
    dbf  = bsq - fac;
    dfb  = fac - bsq;
    if ((a_neg2 != c_neg2) || c_zero2) begin
      dsel   = dsum;
      dneg_c = 1'b0;
    end else if (bsq >= fac) begin
      dsel   = dbf;
      dneg_c = 1'b0;
    end else begin
      dsel   = dfb;
      dneg_c = 1'b1;
    end
  end

  logic              v3;
  logic [DISC_W-1:0] dmag3;
  logic              dneg3, a_zero3, m_neg3, n_neg3;
  logic [DEN_W-1:0]  den3;
  logic [MAG_W-1:0]  mb3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= v2;
    end
    dmag3   <= dsel[DISC_W-1:0];
    dneg3   <= dneg_c;
    a_zero3 <= a_zero2;
    // m = -b/(2a): negative when b and a share a sign and b is nonzero.
    m_neg3  <= (!b_neg2 != a_neg2) && !b_zero2;
    n_neg3  <= a_neg2;
    den3    <= {ma2, 1'b0};
    mb3     <= mb2;
  end

  // Square root of disc << 2*FRAC.
  logic [RAD_W-1:0] radicand;
  sqrt_side_t       side3;

  assign radicand = {(RAD_W - RAD_RAW)'(0), dmag3, (2 * FRAC_BITS)'(0)};

  always_comb begin
    side3.flags.a_zero = a_zero3;
    side3.flags.dneg   = dneg3;
    side3.flags.dzero  = (dmag3 == '0);
    side3.flags.m_neg  = m_neg3;
    side3.flags.n_neg  = n_neg3;
    side3.den          = den3;
    side3.mnum         = DVD_W'({mb3, FRAC_BITS'(0)});
  end

  logic              sq_valid;
  logic [ROOT_W-1:0] sq_root;
  sqrt_side_t        sq_side;

  qrs_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v3),
    .radicand  (radicand),
    .in_side   (side3),
    .out_valid (sq_valid),
    .root      (sq_root),
    .out_side  (sq_side)
  );

  // Both quotients over 2|a|.
  logic             dv_valid;
  logic [DVD_W-1:0] mq, nq;
  flags_t           dv_flags;

  qrs_div u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sq_valid),
    .dvd_m     (sq_side.mnum),
    .dvd_n     (DVD_W'(sq_root)),
    .den       (sq_side.den),
    .in_flags  (sq_side.flags),
    .out_valid (dv_valid),
    .quo_m     (mq),
    .quo_n     (nq),
    .out_flags (dv_flags)
  );

  // Final: signs, sum/difference, saturation.
  logic signed [SUM_W-1:0] m_s, n_s, sum_s, dif_s;
  logic [1:0]              kind_c;
  logic [WORD_BITS-1:0]    first_c, second_c;

  always_comb begin
    m_s   = dv_flags.m_neg ? -$signed(SUM_W'(mq)) : $signed(SUM_W'(mq));
    n_s   = dv_flags.n_neg ? -$signed(SUM_W'(nq)) : $signed(SUM_W'(nq));
    sum_s = m_s + n_s;
    dif_s = m_s - n_s;
    if (dv_flags.a_zero) begin
      kind_c   = KIND_A_ZERO;
      first_c  = '0;
      second_c = '0;
    end else if (dv_flags.dneg) begin
      kind_c   = KIND_COMPLEX;
      first_c  = sat_word(m_s);
      second_c = sat_word(n_s);
    end else begin
      kind_c   = dv_flags.dzero ? KIND_REPEATED : KIND_DISTINCT;
      first_c  = sat_word(sum_s);
      second_c = sat_word(dif_s);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= dv_valid;
    end
    root_kind    <= kind_c;
    first_value  <= first_c;
    second_value <= second_c;
  end

  // Checks
  `QRS_ASSERT_NOW(a_zero_values, done && (root_kind == KIND_A_ZERO), (first_value == '0) && (second_value == '0), "a-zero result with nonzero values")
  `QRS_ASSERT_NOW(repeated_equal, done && (root_kind == KIND_REPEATED), first_value == second_value, "repeated root with unequal values")
  `QRS_ASSERT_NEXT(div_to_done, dv_valid, done, "divider beat did not reach output")

endmodule

// ----- dv/qrs_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// qrs_checker
// Watches the accepted coefficient beats and the result beats of the solver,
// predicts each result in order and compares it field by field.
// ----------------------------------------------------------------------------
module qrs_checker import qrs_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               busy,
  input  logic signed [31:0] coef_a,
  input  logic signed [31:0] coef_b,
  input  logic signed [31:0] coef_c,
  input  logic               done,
  input  logic [1:0]         root_kind,
  input  logic signed [31:0] first_value,
  input  logic signed [31:0] second_value,
  output int                 err_count,
  output int                 pending,
  output int                 kind_seen [4]
);

  typedef struct {
    logic [1:0]  kind;
    logic [31:0] x1;
    logic [31:0] x2;
  } roots_t;

  roots_t root_q[$];

  function automatic logic [31:0] clamp32(input logic signed [127:0] v);
    if (v > 128'sd2147483647) return 32'h7fffffff;
    if (v < -128'sd2147483648) return 32'h80000000;
    return v[31:0];
  endfunction

  // Integer square root, floor, of a nonnegative value.
  function automatic logic [127:0] floor_sqrt(input logic [127:0] x);
    logic [127:0] res;
    logic [127:0] t;
    res = 0;
    for (int i = 63; i >= 0; i--) begin
      t = res | (128'd1 << i);
      if (t * t <= x) res = t;
    end
    return res;
  endfunction

  function automatic roots_t solve_roots(input logic signed [31:0] a,
                                         input logic signed [31:0] b,
                                         input logic signed [31:0] c);
    roots_t r;
    logic signed [127:0] disc, m, n, den;
    logic [127:0] dmag, s;
    if (a == 0) begin
      r.kind = KIND_A_ZERO; r.x1 = 0; r.x2 = 0;
      return r;
    end
    disc = 128'(b) * 128'(b) - 128'sd4 * 128'(a) * 128'(c);
    dmag = (disc < 0) ? 128'(-disc) : 128'(disc);
    den  = 128'sd2 * 128'(a);
    // SV signed division truncates toward zero, as required.
    m = (-128'(b) <<< FRAC_BITS) / den;
    s = floor_sqrt(dmag << (2 * FRAC_BITS));
    n = $signed(s) / den;
    if (disc < 0) begin
      r.kind = KIND_COMPLEX; r.x1 = clamp32(m); r.x2 = clamp32(n);
    end else begin
      r.kind = (disc == 0) ? KIND_REPEATED : KIND_DISTINCT;
      r.x1 = clamp32(m + n); r.x2 = clamp32(m - n);
    end
    return r;
  endfunction

  assign pending = root_q.size();

  initial begin
    err_count = 0;
    for (int k = 0; k < 4; k++) kind_seen[k] = 0;
  end

  always @(posedge clk) begin
    roots_t want;
    if (!rst && start && !busy) root_q.push_back(solve_roots(coef_a, coef_b, coef_c));
    if (!rst && done) begin
      if (root_q.size() == 0) begin
        $display("%0t: result beat with nothing expected", $time);
        err_count++;
      end else begin
        want = root_q.pop_front();
        kind_seen[root_kind]++;
        if (want.kind !== root_kind) begin
          $display("%0t: root_kind exp %0d got %0d", $time, want.kind, root_kind);
          err_count++;
        end
        if (want.x1 !== first_value) begin
          $display("%0t: first_value exp %h got %h", $time, want.x1, first_value);
          err_count++;
        end
        if (want.x2 !== second_value) begin
          $display("%0t: second_value exp %h got %h", $time, want.x2, second_value);
          err_count++;
        end
      end
    end
  end

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the quadratic root solver: directed corner
// coefficient sets, then random beats with varying sender gaps.
// ----------------------------------------------------------------------------
module tb_top;
  import qrs_pkg::*;

  logic               clk, rst, start, busy, done;
  logic signed [31:0] coef_a, coef_b, coef_c;
  logic [1:0]         root_kind;
  logic signed [31:0] first_value, second_value;
  int                 err_count, pending;
  int                 kind_seen [4];
  int                 gap_pct;

  quadratic_root_solver_core DUT (.*);

  qrs_checker u_checker (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Hard limit: ~700 beats plus the pipeline drain fit far inside this.
  initial begin
    #5ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // One beat; holds start high until accepted, optional random gap first.
  task automatic send_coefs(input logic [31:0] a, b, c);
    while ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1; coef_a <= a; coef_b <= b; coef_c <= c;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Random coefficient: mix of full range, small values and extremes.
  function automatic logic [31:0] rand_coef();
    case ($urandom_range(5))
      0: return $urandom;
      1: return 32'($signed($urandom_range(0, 2*65536*8)) - 65536*8);
      2: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
      3: return 32'($signed($urandom_range(0, 64)) - 32);
      default: return 32'($signed($urandom_range(0, 20)) - 10) <<< 16;
    endcase
  endfunction

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    logic [31:0] a, b, c;
    start = 0; coef_a = 0; coef_b = 0; coef_c = 0; gap_pct = 0;
    rst = 1;
    repeat (6) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: a zero, repeated root, complex, distinct, extremes, saturation.
    send_coefs(0, 32'h10000, 32'h10000);
    send_coefs(32'h10000, 32'hfffe0000, 32'h10000);      // (x-1)^2
    send_coefs(32'h10000, 0, 32'h10000);                 // x^2+1
    send_coefs(32'h10000, 0, 32'hffff0000);              // x^2-1
    send_coefs(32'hffff0000, 32'h30000, 32'hfffe0000);   // negative a
    send_coefs(32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
    send_coefs(32'h80000000, 32'h80000000, 32'h80000000);
    send_coefs(32'h80000000, 32'h7fffffff, 32'h7fffffff);
    send_coefs(1, 32'h7fffffff, 0);                      // saturating roots
    send_coefs(1, 32'h80000000, 1);
    send_coefs(32'hffffffff, 0, 32'h7fffffff);
    send_coefs(1, 0, 0);                                 // repeated at zero
    send_coefs(32'h10000, 0, 0);
    send_coefs(1, 2, 1);
    send_coefs(32'hffffffff, 32'hffffffff, 32'hffffffff);
    send_coefs(0, 32'h80000000, 32'h7fffffff);
    send_coefs(32'h7fffffff, 0, 32'h80000000);
    // Pause with everything drained before the random part.
    drain();

    for (int phase = 0; phase < 3; phase++) begin
      gap_pct = (phase == 0) ? 30 : (phase == 1) ? 67 : 0;
      for (int i = 0; i < 200; i++) begin
        a = rand_coef(); b = rand_coef(); c = rand_coef();
        // Repeated roots: b = 2k, a = 1.0, c = k*k scaled.
        if ($urandom_range(9) == 0) begin
          a = 32'h10000;
          b = 32'($signed($urandom_range(0, 40)) - 20) <<< 17;
          c = (($signed(b) >>> 17) * ($signed(b) >>> 17)) <<< 16;
        end
        if ($urandom_range(19) == 0) a = 0;
        send_coefs(a, b, c);
      end
    end
    drain();
    repeat (120) @(posedge clk);

    $display("Covered %0d directed and 600 random beats over three gap profiles;",
             17);
    $display("kinds seen: complex %0d repeated %0d distinct %0d a-zero %0d",
             kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3]);
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+design
design/qrs_pkg.sv
design/qrs_sqrt.sv
design/qrs_div.sv
design/quadratic_root_solver_core.sv
dv/qrs_checker.sv
dv/tb_top.sv
